/* sv/radix2_fft_forward_inverse_top_assert.svh */
// Assertion macros used by the checker file of the transform block.
`ifndef RADIX2_FFT_FORWARD_INVERSE_TOP_ASSERT_SVH
`define RADIX2_FFT_FORWARD_INVERSE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/r2fft_pkg.sv */
// Package with types, constants and the twiddle table of the transform block.
package r2fft_pkg;
    localparam int BIN_W   = 22;
    localparam int ROM_LOG2 = 6;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_POINTS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 1'd1;

    typedef logic signed [BIN_W-1:0] bin_t;

    // Quarter-wave sine table, Q1.15, 64-point grid.
    function automatic logic [15:0] sine_rom(input logic [4:0] k);
        logic [15:0] v;
        begin
            case (k)
                5'd0: v = 16'd0;
                5'd1: v = 16'd3212;
                5'd2: v = 16'd6393;
                5'd3: v = 16'd9512;
                5'd4: v = 16'd12540;
                5'd5: v = 16'd15447;
                5'd6: v = 16'd18205;
                5'd7: v = 16'd20788;
                5'd8: v = 16'd23170;
                5'd9: v = 16'd25330;
                5'd10: v = 16'd27246;
                5'd11: v = 16'd28899;
                5'd12: v = 16'd30274;
                5'd13: v = 16'd31357;
                5'd14: v = 16'd32138;
                5'd15: v = 16'd32610;
                5'd16: v = 16'd32767;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

    // Saturation of a wide value to the bin width.
    function automatic bin_t sat_bin(input logic signed [39:0] v);
        bin_t r;
        begin
            if (v > 40'sd2097151)
                r = 22'sd2097151;
            else if (v < -40'sd2097152)
                r = -22'sd2097152;
            else
                r = v[BIN_W-1:0];
            return r;
        end
    endfunction
endpackage

/* sv/r2fft_if.sv */
// Handshake interfaces for the sample, bin and configuration channels.
interface r2fft_sample_if #(parameter int SW = 16);
    logic valid;
    logic ready;
    logic signed [SW-1:0] sample_re;
    logic signed [SW-1:0] sample_im;
    modport source (output valid, sample_re, sample_im, input ready);
    modport sink (input valid, sample_re, sample_im, output ready);
endinterface

interface r2fft_bin_if;
    logic valid;
    logic ready;
    logic signed [21:0] bin_re;
    logic signed [21:0] bin_im;
    logic last_bin;
    modport source (output valid, bin_re, bin_im, last_bin, input ready);
    modport sink (input valid, bin_re, bin_im, last_bin, output ready);
endinterface

interface r2fft_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [2:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/r2fft_bfly.sv */
// Pipelined butterfly: complex twiddle product, rounding, add and subtract.
module r2fft_bfly
    import r2fft_pkg::*;
(
    input  logic               clk,
    input  logic               inv,
    input  bin_t               ar,
    input  bin_t               ai,
    input  bin_t               br,
    input  bin_t               bi,
    input  logic signed [16:0] wr,
    input  logic signed [16:0] wi,
    output bin_t               r0,
    output bin_t               i0,
    output bin_t               r1,
    output bin_t               i1
);
    logic signed [38:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    bin_t ar_reg, ai_reg;
    logic signed [40:0] sum_r, sum_i;
    logic signed [25:0] tr, ti;
    logic signed [26:0] s0r, s0i, s1r, s1i;

    // Four products, registered.
    always_ff @(posedge clk)
    begin
        p_rr_reg <= 39'(wr * br);
        p_ii_reg <= 39'(wi * bi);
        p_ri_reg <= 39'(wr * bi);
        p_ir_reg <= 39'(wi * br);
        ar_reg   <= ar;
        ai_reg   <= ai;
    end

    // Round by 15 bits, ties towards plus infinity, add and subtract, halve in inverse mode, saturate.
    always_comb
    begin
        sum_r = 41'(p_rr_reg) - 41'(p_ii_reg) + 41'sd16384;
        sum_i = 41'(p_ri_reg) + 41'(p_ir_reg) + 41'sd16384;
        tr = 26'(sum_r >>> 15);
        ti = 26'(sum_i >>> 15);
        s0r = 27'(ar_reg) + 27'(tr);
        s0i = 27'(ai_reg) + 27'(ti);
        s1r = 27'(ar_reg) - 27'(tr);
        s1i = 27'(ai_reg) - 27'(ti);
        if (inv)
        begin
            s0r = (s0r + 27'sd1) >>> 1;
            s0i = (s0i + 27'sd1) >>> 1;
            s1r = (s1r + 27'sd1) >>> 1;
            s1i = (s1i + 27'sd1) >>> 1;
        end
        r0 = sat_bin(40'(s0r));
        i0 = sat_bin(40'(s0i));
        r1 = sat_bin(40'(s1r));
        i1 = sat_bin(40'(s1i));
    end
endmodule

/* sv/radix2_fft_forward_inverse_top.sv */
// Top level of the radix-2 decimation-in-time transform.
// Usage:
// Samples arrive on the sample channel, one per transfer; each is written at
// the bit-reversed address of its place in the frame. Configuration writes on
// the cfg channel set the length (register 0) and the inverse mode
// (register 1); write them only while the block is idle.
// After the N-th sample the block stops taking samples and runs log2 N stages
// of N/2 butterflies. Each butterfly reads two entries from the point memory
// (state RD), multiplies (state MUL) and writes both results back (state WR)
// on the single memory port pair. Bins then leave in natural order, one memory
// read per bin through an output register, with last_bin on the final one.
// Only one read is in flight at a time: the next bin is not read until the
// previous one has reached the output register. When the receiver stalls the
// output register holds its bin and the unload waits. Reset clears the load
// count and control; registers return to length 64 and forward mode. The
// point memory is not cleared.
module radix2_fft_forward_inverse_top
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS   = 64,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    r2fft_sample_if.sink   in_ch,
    r2fft_bin_if.source    out_ch,
    r2fft_cfg_if.sink      cfg
);
    localparam int AW = ($clog2(MAX_POINTS + 1) - 1 > 6) ? 6 : $clog2(MAX_POINTS + 1) - 1;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_RD    = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_WR    = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] log2_reg;
    logic inv_reg;
    logic [AW:0] cnt_reg, cnt_next;
    logic [2:0] stage_reg, stage_next;
    logic [AW-1:0] bf_reg, bf_next;
    logic [AW:0] rd_reg, rd_next;

    logic [2:0] lg;
    logic [AW:0] npts;
    logic [AW-1:0] ia, ib, jj;
    logic [AW-1:0] ia_hold_reg, ib_hold_reg;
    logic [2*BIN_W-1:0] mem [DEPTH];
    logic [2*BIN_W-1:0] qa_reg, qb_reg;
    logic [4:0] tk;
    logic signed [16:0] wr, wi, c, s;
    bin_t r0, i0, r1, i1;
    logic out_valid_reg;
    bin_t out_re_reg, out_im_reg;
    logic out_last_reg;
    logic pend_reg, pend_last_reg;
    logic take_in, out_free, rd_fire;
    logic [AW-1:0] wa, la;
    logic [AW:0] lc;
    logic signed [SAMPLE_WIDTH-1:0] sre, sim;

    // Active length, limited by the parameter.
    assign lg = (log2_reg > 3'(AW)) ? 3'(AW) : log2_reg;
    assign npts = (AW+1)'(1) << lg;

    // Configuration registers.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg <= 3'd6;
            inv_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_LOG2_POINTS)
                log2_reg <= cfg.data;
            else
                inv_reg <= cfg.data[0];
        end
    end

    // Bit-reversed load address.
    always_comb
    begin
        lc = (cnt_reg >= npts) ? '0 : cnt_reg;
        la = '0;
        for (int i = 0; i < AW; i++)
            if (i < int'(lg))
                la[i] = lc[int'(lg) - 1 - i];
    end

    // Butterfly addresses and twiddle.
    always_comb
    begin
        jj = bf_reg & ((AW)'((1 << stage_reg) - 1));
        ia = ((bf_reg >> stage_reg) << (stage_reg + 3'd1)) | jj;
        ib = ia | (AW)'(1 << stage_reg);
        tk = 5'((32'(jj) << (3'd5 - stage_reg)) & 32'd31);
        if (tk <= 5'd16)
        begin
            c = 17'(sine_rom(5'd16 - tk));
            s = 17'(sine_rom(tk));
        end
        else
        begin
            c = -17'(sine_rom(tk - 5'd16));
            s = 17'(sine_rom(5'd0 - tk));
        end
        wr = c;
        wi = inv_reg ? s : -s;
    end

    r2fft_bfly u_bfly (
        .clk(clk), .inv(inv_reg),
        .ar(bin_t'(qa_reg[2*BIN_W-1:BIN_W])), .ai(bin_t'(qa_reg[BIN_W-1:0])),
        .br(bin_t'(qb_reg[2*BIN_W-1:BIN_W])), .bi(bin_t'(qb_reg[BIN_W-1:0])),
        .wr(wr), .wi(wi), .r0(r0), .i0(i0), .r1(r1), .i1(i1)
    );

    assign in_ch.ready = (state_reg == ST_LOAD);
    assign take_in = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign rd_fire = (state_reg == ST_OUT) && (rd_reg < npts) && out_free && !pend_reg;
    assign sre = in_ch.sample_re;
    assign sim = in_ch.sample_im;
    assign wa = (state_reg == ST_OUT) ? rd_reg[AW-1:0] : ia;

    // Point memory: two reads, writes at the butterfly pair or load address.
    always_ff @(posedge clk)
    begin
        if (take_in)
            mem[la] <= {sat_bin(40'(sre)), sat_bin(40'(sim))};
        else if (state_reg == ST_WR)
        begin
            mem[ia_hold_reg] <= {r0, i0};
            mem[ib_hold_reg] <= {r1, i1};
        end
        qa_reg <= mem[wa];
        qb_reg <= mem[ib];
        if (state_reg == ST_RD)
        begin
            ia_hold_reg <= ia;
            ib_hold_reg <= ib;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        stage_next = stage_reg;
        bf_next = bf_reg;
        rd_next = rd_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (take_in)
                begin
                    cnt_next = lc + 1'b1;
                    if (lc + 1'b1 >= npts)
                    begin
                        cnt_next = '0;
                        stage_next = '0;
                        bf_next = '0;
                        rd_next = '0;
                        state_next = (lg == 3'd0) ? ST_OUT : ST_RD;
                    end
                end
            end
            ST_RD:  state_next = ST_MUL;
            ST_MUL: state_next = ST_WR;
            ST_WR:
            begin
                state_next = ST_RD;
                if ((AW+1)'(bf_reg) + 1'b1 >= (npts >> 1))
                begin
                    bf_next = '0;
                    stage_next = stage_reg + 3'd1;
                    if (stage_reg + 3'd1 >= lg)
                        state_next = ST_OUT;
                end
                else
                    bf_next = bf_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (rd_fire)
                    rd_next = rd_reg + 1'b1;
                if (rd_reg >= npts && !out_valid_reg && !pend_reg)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            stage_reg <= '0;
            bf_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            stage_reg <= stage_next;
            bf_reg <= bf_next;
            rd_reg <= rd_next;
        end
    end

    // Output register; memory read data passes through qa_reg, flagged by pend_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_fire;
            if (pend_reg)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_last_reg <= (rd_reg == npts - 1'b1);
        if (pend_reg)
        begin
            out_re_reg <= bin_t'(qa_reg[2*BIN_W-1:BIN_W]);
            out_im_reg <= bin_t'(qa_reg[BIN_W-1:0]);
            out_last_reg <= pend_last_reg;
        end
    end

    // rd_fire needs the output slot free and no read in flight.
    assign out_ch.valid = out_valid_reg;
    assign out_ch.bin_re = out_re_reg;
    assign out_ch.bin_im = out_im_reg;
    assign out_ch.last_bin = out_last_reg;
endmodule

/* sv/r2fft_checker.sv */
// Port checker for the transform block and its bind.
`include "radix2_fft_forward_inverse_top_assert.svh"
module r2fft_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last
);
    `FFT_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while bins pending")
    `FFT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "bin dropped while stalled")
    `FFT_ASSERT_NEXT(a_last_end, clk, rst_n, out_valid && out_ready && out_last && !in_ready, !out_valid || !out_last, "last repeated")
endmodule

bind radix2_fft_forward_inverse_top r2fft_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last_bin)
);

/* verif/tb_radix2_fft_forward_inverse_top.sv */
// Self-checking testbench for the radix-2 forward and inverse transform block.
`timescale 1ns / 100ps

module tb_radix2_fft_forward_inverse_top
    import r2fft_pkg::*;
();

    localparam int CLK_HALF   = 6;
    localparam int QUIET_GAP  = 40;
    localparam int HOLD_LEN   = 1500;
    localparam int STALL_MAX  = 6000;
    localparam int MAX_REPORT = 10;
    localparam int RAND_ITEMS = 280;

    typedef enum logic [1:0] {JOB_SAMPLE, JOB_CFG, JOB_SYNC, JOB_HOLD} job_kind_e;

    typedef struct {
        job_kind_e   kind;
        logic [15:0] re;
        logic [15:0] im;
        logic [0:0]  index;
        logic [2:0]  data;
        int          send_pct;
        int          recv_pct;
    } job_t;

    typedef struct {
        bin_t re;
        bin_t im;
        logic last;
    } bin_exp_t;

    logic clk;
    logic rst_n;

    r2fft_sample_if #(.SW(16)) s_if ();
    r2fft_bin_if               b_if ();
    r2fft_cfg_if               c_if ();

    job_t     job_q[$];
    bin_exp_t bin_q[$];

    // Predictor state.
    bin_t       pt_re[64];
    bin_t       pt_im[64];
    int         frame_fill;
    logic [2:0] len_log2;
    logic       inv_mode;

    int send_idle;
    int recv_idle;
    int hold_seq;
    int quiet_left;
    int mismatches;
    int calm_cycles;

    radix2_fft_forward_inverse_top #(
        .MAX_POINTS   (64),
        .SAMPLE_WIDTH (16)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (s_if.sink),
        .out_ch (b_if.source),
        .cfg    (c_if.sink)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Quarter-wave sine values in Q1.15 on the 64-point grid.
    function automatic longint quarter_sine(input int k);
        case (k)
            0: return 0;          1: return 3212;       2: return 6393;
            3: return 9512;       4: return 12540;      5: return 15447;
            6: return 18205;      7: return 20788;      8: return 23170;
            9: return 25330;      10: return 27246;     11: return 28899;
            12: return 30274;     13: return 31357;     14: return 32138;
            15: return 32610;     default: return 32767;
        endcase
    endfunction

    // Clamp a wide value to the signed bin range.
    function automatic bin_t clamp_bin(input longint v);
        if (v > 2097151)
            return 22'sd2097151;
        if (v < -2097152)
            return -22'sd2097152;
        return bin_t'(v);
    endfunction

    function automatic int bit_rev(input int n, input int bits);
        int r;
        r = 0;
        for (int i = 0; i < bits; i++)
            r = (r << 1) | ((n >> i) & 1);
        return r;
    endfunction

    // Load one sample and, on the final sample of a frame, compute all bins.
    task automatic load_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        int     n;
        int     lg;
        int     ia;
        int     ib;
        int     k;
        longint wr;
        longint wi;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint tr;
        longint ti;
        longint r0;
        longint i0;
        longint r1;
        longint i1;
        bin_exp_t e;
        lg = (len_log2 > 6) ? 6 : int'(len_log2);
        n = 1 << lg;
        if (frame_fill >= n)
            frame_fill = 0;
        ia = bit_rev(frame_fill, lg);
        pt_re[ia] = bin_t'(re);
        pt_im[ia] = bin_t'(im);
        frame_fill++;
        if (frame_fill < n)
            return;
        frame_fill = 0;
        // Butterfly stages in place, decimation in time.
        for (int st = 0; st < lg; st++)
        begin
            for (int g = 0; g < n; g += (2 << st))
            begin
                for (int j = 0; j < (1 << st); j++)
                begin
                    ia = g + j;
                    ib = g + j + (1 << st);
                    k = (j << (5 - st)) & 31;
                    if (k <= 16)
                    begin
                        wr = quarter_sine(16 - k);
                        wi = quarter_sine(k);
                    end
                    else
                    begin
                        wr = -quarter_sine(k - 16);
                        wi = quarter_sine(32 - k);
                    end
                    if (!inv_mode)
                        wi = -wi;
                    ar = pt_re[ia];
                    ai = pt_im[ia];
                    br = pt_re[ib];
                    bi = pt_im[ib];
                    tr = (wr * br - wi * bi + 16384) >>> 15;
                    ti = (wr * bi + wi * br + 16384) >>> 15;
                    r0 = ar + tr;
                    i0 = ai + ti;
                    r1 = ar - tr;
                    i1 = ai - ti;
                    if (inv_mode)
                    begin
                        r0 = (r0 + 1) >>> 1;
                        i0 = (i0 + 1) >>> 1;
                        r1 = (r1 + 1) >>> 1;
                        i1 = (i1 + 1) >>> 1;
                    end
                    pt_re[ia] = clamp_bin(r0);
                    pt_im[ia] = clamp_bin(i0);
                    pt_re[ib] = clamp_bin(r1);
                    pt_im[ib] = clamp_bin(i1);
                end
            end
        end
        for (int b = 0; b < n; b++)
        begin
            e.re = pt_re[b];
            e.im = pt_im[b];
            e.last = (b == n - 1);
            bin_q.insert(bin_q.size(), e);
        end
    endtask

    // Sample and configuration driver.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic nxt_s;
        logic nxt_c;
        job_t j;
        if (!rst_n)
        begin
            s_if.valid <= 1'b0;
            c_if.valid <= 1'b0;
            quiet_left = 0;
        end
        else
        begin
            nxt_s = s_if.valid;
            nxt_c = c_if.valid;
            // Account for the transfers of this edge.
            if (s_if.valid && s_if.ready)
            begin
                load_sample(s_if.sample_re, s_if.sample_im);
                nxt_s = 1'b0;
            end
            if (c_if.valid && c_if.ready)
            begin
                if (c_if.index == REG_LOG2_POINTS)
                    len_log2 = c_if.data;
                else
                    inv_mode = c_if.data[0];
                nxt_c = 1'b0;
            end
            // Offer the next pending job.
            if (quiet_left > 0)
                quiet_left--;
            else if (!nxt_s && !nxt_c && job_q.size() > 0)
            begin
                j = job_q[0];
                case (j.kind)
                    JOB_SAMPLE:
                        if ($urandom_range(0, 99) >= send_idle)
                        begin
                            nxt_s = 1'b1;
                            s_if.sample_re <= j.re;
                            s_if.sample_im <= j.im;
                            void'(job_q.pop_front());
                        end
                    JOB_CFG:
                    begin
                        nxt_c = 1'b1;
                        c_if.index <= j.index;
                        c_if.data <= j.data;
                        void'(job_q.pop_front());
                    end
                    JOB_SYNC:
                        if (bin_q.size() == 0)
                        begin
                            quiet_left = QUIET_GAP;
                            send_idle = j.send_pct;
                            recv_idle <= j.recv_pct;
                            void'(job_q.pop_front());
                        end
                    default:
                    begin
                        hold_seq <= hold_seq + 1;
                        void'(job_q.pop_front());
                    end
                endcase
            end
            s_if.valid <= nxt_s;
            c_if.valid <= nxt_c;
        end
    end

    // Bin monitor with random and long back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        int       hold_left;
        int       hold_seen;
        bin_exp_t e;
        if (!rst_n)
        begin
            b_if.ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (b_if.valid && b_if.ready)
            begin
                if (bin_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("Unexpected bin transfer: re %0d im %0d last %0b",
                                 b_if.bin_re, b_if.bin_im, b_if.last_bin);
                end
                else
                begin
                    e = bin_q.pop_front();
                    if (b_if.bin_re !== e.re || b_if.bin_im !== e.im
                        || b_if.last_bin !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT)
                            $display("Bin mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                     e.re, e.im, e.last,
                                     b_if.bin_re, b_if.bin_im, b_if.last_bin);
                    end
                end
            end
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                b_if.ready <= 1'b0;
            end
            else
                b_if.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (s_if.valid && s_if.ready) || (b_if.valid && b_if.ready)
            || (c_if.valid && c_if.ready))
            calm_cycles <= 0;
        else if (calm_cycles >= STALL_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            calm_cycles <= calm_cycles + 1;
    end

    task automatic add_sample(input logic [15:0] re, input logic [15:0] im);
        job_t j;
        j = '{kind: JOB_SAMPLE, re: re, im: im, index: '0, data: '0,
              send_pct: 0, recv_pct: 0};
        job_q.insert(job_q.size(), j);
    endtask

    task automatic add_cfg(input logic [0:0] index, input logic [2:0] data);
        job_t j;
        j = '{kind: JOB_CFG, re: '0, im: '0, index: index, data: data,
              send_pct: 0, recv_pct: 0};
        job_q.insert(job_q.size(), j);
    endtask

    // Wait for the block to drain, then change the idling percentages.
    task automatic add_sync(input int sp, input int rp);
        job_t j;
        j = '{kind: JOB_SYNC, re: '0, im: '0, index: '0, data: '0,
              send_pct: sp, recv_pct: rp};
        job_q.insert(job_q.size(), j);
    endtask

    task automatic add_hold();
        job_t j;
        j = '{kind: JOB_HOLD, re: '0, im: '0, index: '0, data: '0,
              send_pct: 0, recv_pct: 0};
        job_q.insert(job_q.size(), j);
    endtask

    function automatic logic [15:0] rand_part();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_frames(input int lg, input logic inv, input int count,
                              inout int total);
        add_cfg(REG_LOG2_POINTS, 3'(lg));
        add_cfg(REG_INVERSE_MODE, {2'b00, inv});
        for (int f = 0; f < count * (1 << lg); f++)
            add_sample(rand_part(), rand_part());
        total += count * (1 << lg);
    endtask

    // Stimulus, end of run and verdict.
    initial
    begin
        int sp;
        int rp;
        int total;
        int lg;
        rst_n = 1'b0;
        s_if.valid = 1'b0;
        s_if.sample_re = '0;
        s_if.sample_im = '0;
        c_if.valid = 1'b0;
        c_if.index = '0;
        c_if.data = '0;
        b_if.ready = 1'b0;
        frame_fill = 0;
        len_log2 = 3'd6;
        inv_mode = 1'b0;
        send_idle = 25;
        recv_idle = 59;
        hold_seq = 0;
        mismatches = 0;
        calm_cycles = 0;
        total = 0;

        // Directed: single point, forward, extremes.
        add_sync(25, 59);
        add_cfg(REG_LOG2_POINTS, 3'd0);
        add_cfg(REG_INVERSE_MODE, 3'd0);
        add_sample(16'h7fff, 16'h8000);
        add_sample(16'h8000, 16'h7fff);
        add_sample(16'h0000, 16'hffff);
        // Two points, inverse.
        add_sync(25, 59);
        add_cfg(REG_LOG2_POINTS, 3'd1);
        add_cfg(REG_INVERSE_MODE, 3'd1);
        add_sample(16'h7fff, 16'h7fff);
        add_sample(16'h8000, 16'h8000);
        // Four points, forward, full negative scale for the largest growth.
        add_sync(25, 59);
        add_cfg(REG_LOG2_POINTS, 3'd2);
        add_cfg(REG_INVERSE_MODE, 3'd0);
        for (int i = 0; i < 4; i++)
            add_sample(16'h8000, 16'h8000);
        // Eight points, inverse, a partial frame then a shorter length drops it.
        add_sync(25, 59);
        add_cfg(REG_LOG2_POINTS, 3'd3);
        add_cfg(REG_INVERSE_MODE, 3'd1);
        for (int i = 0; i < 5; i++)
            add_sample(16'h5555 << i, 16'haaaa >> i);
        add_sync(25, 59);
        add_cfg(REG_LOG2_POINTS, 3'd1);
        add_sample(16'h7fff, 16'h0001);
        add_sample(16'h8001, 16'h8000);

        // Random phases: three idling regimes, each opening with full-length frames.
        // In the last one the receiver holds off while a second frame is offered.
        for (int ph = 0; ph < 3; ph++)
        begin
            sp = (ph == 0) ? 25 : (ph == 1) ? 59 : 0;
            rp = (ph == 0) ? 59 : (ph == 1) ? 25 : 0;
            add_sync(sp, rp);
            if (ph == 2)
                add_hold();
            add_frames(6, ph == 1, (ph == 2) ? 2 : 1, total);
            while (total < (ph + 1) * RAND_ITEMS / 3)
            begin
                add_sync(sp, rp);
                lg = ($urandom_range(0, 9) == 0) ? 6 : int'($urandom_range(0, 5));
                add_frames(lg, 1'($urandom_range(0, 1)), int'($urandom_range(1, 2)), total);
            end
        end
        add_sync(0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (job_q.size() > 0 || s_if.valid || c_if.valid || bin_q.size() > 0)
            @(posedge clk);
        repeat (QUIET_GAP) @(posedge clk);
        if (bin_q.size() > 0)
            mismatches++;
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/r2fft_pkg.sv
sv/r2fft_if.sv
sv/r2fft_bfly.sv
sv/radix2_fft_forward_inverse_top.sv
sv/r2fft_checker.sv
verif/tb_radix2_fft_forward_inverse_top.sv
